### hw/rtl/pcc_pkg.sv
// PWM period/compare calculator: shared types, codes and constants.
// No dependencies.
package pcc_pkg;

  localparam int unsigned COUNTER_MAX = 65535;
  localparam int unsigned CMAX_W      = 16;
  localparam int unsigned DVD_W       = 34;  // dividend / quotient width
  localparam int unsigned DVS_W       = 32;  // divisor width
  localparam int unsigned CNT_W       = 6;   // holds DVD_W
  localparam int unsigned PRE_W       = 18;  // prescaler before range check
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DAT_W   = 32;
  localparam int unsigned DUTY_MAX    = 100;
  localparam int unsigned RELOAD_MIN  = 100;

  localparam logic CMD_SET_FREQ = 1'b0;
  localparam logic CMD_SET_DUTY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BUS_CLOCK_HZ  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUS_PRESCALED = 8'd1;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_BAD_FREQ     = 3'd1,
    STAT_RELOAD_SMALL = 3'd2,
    STAT_RANGE_OVF    = 3'd3,
    STAT_DUTY_OVER    = 3'd4
  } status_t;

endpackage

### hw/rtl/pcc_if.sv
// Handshake channels of the PWM period/compare calculator.
// Depends on pcc_pkg.
interface pcc_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] freq_hz;
  logic [7:0]  duty_percent;
  modport source (output valid, cmd, freq_hz, duty_percent, input ready);
  modport sink   (input valid, cmd, freq_hz, duty_percent, output ready);
endinterface

interface pcc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] prescaler;
  logic [15:0] reload;
  logic [15:0] compare;
  modport source (output valid, status, prescaler, reload, compare, input ready);
  modport sink   (input valid, status, prescaler, reload, compare, output ready);
endinterface

interface pcc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pcc_pkg::CFG_IDX_W-1:0] index;
  logic [pcc_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/pwm_period_and_compare_calc_core.sv
// PWM period/compare calculator top level: sequencer around one shared
// restoring divider. Depends on pcc_pkg and the channels in pcc_if.sv.
//
//  channel | dir | payload                               | role
//  req     | in  | cmd, freq_hz, duty_percent            | set frequency / set duty
//  rsp     | out | status, prescaler, reload, compare    | one per request
//  cfg     | in  | index, data                           | bus clock registers
//
// Cycles: the divider resolves one quotient bit per cycle, and each pass
// is followed by a sequencing state. Set frequency takes one pass (reload
// in range) or three (reload over COUNTER_MAX: prescaler, then scaled
// reload); set duty one pass; rejected or zero-duty requests no pass. A new
// request is taken once the result is in the output register. Reset (rst,
// synchronous) clears the sequencer, the stored timer values and the
// registers to their defaults. A stalled rsp holds the result; the next
// request may still be worked on.
module pwm_period_and_compare_calc_core (
  input  logic      clk,
  input  logic      rst,
  pcc_req_if.sink   req,
  pcc_rsp_if.source rsp,
  pcc_cfg_if.sink   cfg
);
  import pcc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_NEXT = 3'b100
  } state_t;

  // what the finished division means
  typedef enum logic [4:0] {
    PH_RELOAD = 5'b00001,
    PH_PRESC  = 5'b00010,
    PH_SCALE  = 5'b00100,
    PH_DUTY   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  state_t state;
  phase_t phase;

  // configuration registers
  logic [30:0] bus_clock_hz;
  logic        bus_prescaled;

  // stored timer settings (minus one)
  logic [CMAX_W-1:0] stored_prescaler;
  logic [CMAX_W-1:0] stored_reload;

  // shared divider
  logic [DVD_W-1:0] dvd;   // dividend in, quotient out
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;

  logic [DVS_W:0]   rem_sh;
  logic             rem_ge;
  logic [DVS_W:0]   rem_sub;

  // working values
  logic [DVD_W-1:0] r_val;
  logic [PRE_W-1:0] p_val;
  status_t          pend_status;
  logic [CMAX_W-1:0] pend_cmp;

  // request decode
  logic             req_fire;
  logic [32:0]      tclk;
  logic             bad_freq;
  logic [DVD_W-1:0] reload_num;
  logic [23:0]      duty_prod;

  // finish path
  logic             out_free;
  logic             rsp_load;
  logic             fin_freq;
  logic [DVD_W-1:0] fin_r;
  logic [PRE_W-1:0] fin_p;
  status_t          fin_status;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid & req.ready;
  assign out_free  = ~rsp.valid | rsp.ready;

  // result goes to the output register this cycle
  assign rsp_load = (state == ST_NEXT) && out_free && (phase != PH_PRESC) &&
                    !(phase == PH_RELOAD && !fin_freq);

  assign tclk       = bus_prescaled ? {1'b0, bus_clock_hz, 1'b0} : {2'b00, bus_clock_hz};
  assign bad_freq   = (req.freq_hz == 32'd0) || ({1'b0, req.freq_hz} >= tclk);
  assign reload_num = {1'b0, tclk} + {3'b000, req.freq_hz[31:1]};
  assign duty_prod  = stored_reload * req.duty_percent;

  // one restoring step
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs});
  assign rem_sub = rem_sh - {1'b0, dvs};

  // final range checks of a set-frequency request
  always_comb begin
    fin_freq = 1'b0;
    fin_r    = dvd;
    fin_p    = PRE_W'(1);
    if (phase == PH_RELOAD && dvd <= DVD_W'(COUNTER_MAX)) begin
      fin_freq = 1'b1;
    end else if (phase == PH_SCALE) begin
      fin_freq = 1'b1;
      fin_p    = p_val;
    end
    if (fin_r <= DVD_W'(RELOAD_MIN)) begin
      fin_status = STAT_RELOAD_SMALL;
    end else if (fin_p > PRE_W'(COUNTER_MAX) || fin_r > DVD_W'(COUNTER_MAX)) begin
      fin_status = STAT_RANGE_OVF;
    end else begin
      fin_status = STAT_OK;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_clock_hz  <= 31'd16000000;
      bus_prescaled <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_BUS_CLOCK_HZ:  bus_clock_hz  <= cfg.data[30:0];
        REG_BUS_PRESCALED: bus_prescaled <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // sequencer, divider and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      phase            <= PH_DONE;
      cnt              <= '0;
      stored_prescaler <= '0;
      stored_reload    <= '0;
      rsp.valid        <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            rem      <= '0;
            cnt      <= CNT_W'(DVD_W);
            pend_cmp <= '0;
            if (req.cmd == CMD_SET_FREQ) begin
              if (bad_freq) begin
                pend_status <= STAT_BAD_FREQ;
                phase       <= PH_DONE;
                state       <= ST_NEXT;
              end else begin
                dvd   <= reload_num;
                dvs   <= req.freq_hz;
                phase <= PH_RELOAD;
                state <= ST_DIV;
              end
            end else if (req.duty_percent > 8'(DUTY_MAX)) begin
              pend_status <= STAT_DUTY_OVER;
              phase       <= PH_DONE;
              state       <= ST_NEXT;
            end else if (req.duty_percent == 8'd0) begin
              pend_status <= STAT_OK;
              phase       <= PH_DONE;
              state       <= ST_NEXT;
            end else begin
              dvd   <= DVD_W'(duty_prod);
              dvs   <= DVS_W'(DUTY_MAX);
              phase <= PH_DUTY;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
          dvd <= {dvd[DVD_W-2:0], rem_ge};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (phase == PH_RELOAD && !fin_freq) begin
            // reload too large: prescaler = round(r / COUNTER_MAX) + 1
            r_val <= dvd;
            dvd   <= dvd + DVD_W'(COUNTER_MAX / 2);
            dvs   <= DVS_W'(COUNTER_MAX);
            rem   <= '0;
            cnt   <= CNT_W'(DVD_W);
            phase <= PH_PRESC;
            state <= ST_DIV;
          end else if (phase == PH_PRESC) begin
            p_val <= dvd[PRE_W-1:0] + PRE_W'(1);
            dvd   <= r_val;
            dvs   <= DVS_W'(dvd[PRE_W-1:0] + PRE_W'(1));
            rem   <= '0;
            cnt   <= CNT_W'(DVD_W);
            phase <= PH_SCALE;
            state <= ST_DIV;
          end else if (out_free) begin
            rsp.valid     <= 1'b1;
            rsp.prescaler <= stored_prescaler;
            rsp.reload    <= stored_reload;
            rsp.compare   <= '0;
            state         <= ST_IDLE;
            if (fin_freq) begin
              rsp.status <= fin_status;
              if (fin_status == STAT_OK) begin
                stored_prescaler <= CMAX_W'(fin_p - PRE_W'(1));
                stored_reload    <= CMAX_W'(fin_r - DVD_W'(1));
                rsp.prescaler    <= CMAX_W'(fin_p - PRE_W'(1));
                rsp.reload       <= CMAX_W'(fin_r - DVD_W'(1));
              end
            end else if (phase == PH_DUTY) begin
              rsp.status  <= STAT_OK;
              rsp.compare <= dvd[CMAX_W-1:0] + CMAX_W'(1);
            end else begin
              rsp.status  <= pend_status;
              rsp.compare <= pend_cmp;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_cnt_in_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt != '0)
    else $error("divider running with no steps left");

  a_store_on_ok: assert property (@(posedge clk) disable iff (rst)
    !$stable(stored_reload) |-> rsp.valid && rsp.status == STAT_OK && rsp.reload == stored_reload)
    else $error("stored reload changed without an ok response");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status <= STAT_DUTY_OVER)
    else $error("status code out of range");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for pwm_period_and_compare_calc_core.
// Depends on pcc_pkg, the channels in pcc_if.sv and the core itself.
module tb;
  import pcc_pkg::*;

  // One result as the core reports it.
  typedef struct packed {
    status_t     status;
    logic [15:0] prescaler;
    logic [15:0] reload;
    logic [15:0] compare;
  } timer_result_t;

  // Directed stimulus row; rows with fixed_res set carry a typed-in answer.
  typedef struct packed {
    logic          cmd;
    logic [31:0]   freq_hz;
    logic [7:0]    duty_percent;
    logic          fixed_res;
    timer_result_t res;
  } directed_row_t;

  localparam timer_result_t NO_RES = '{STAT_OK, 16'd0, 16'd0, 16'd0};

  // Typed rows come first, while the stored timer values are still zero.
  localparam directed_row_t DIRECTED [0:21] = '{
    '{CMD_SET_DUTY, 32'd0,         8'd50,  1'b1, '{STAT_OK, 16'd0, 16'd0, 16'd1}},
    '{CMD_SET_DUTY, 32'd0,         8'd0,   1'b1, NO_RES},
    '{CMD_SET_DUTY, 32'd0,         8'd101, 1'b1, '{STAT_DUTY_OVER, 16'd0, 16'd0, 16'd0}},
    '{CMD_SET_DUTY, 32'hFFFFFFFF,  8'd255, 1'b1, '{STAT_DUTY_OVER, 16'd0, 16'd0, 16'd0}},
    '{CMD_SET_FREQ, 32'd0,         8'd0,   1'b1, '{STAT_BAD_FREQ, 16'd0, 16'd0, 16'd0}},
    '{CMD_SET_FREQ, 32'd16000000,  8'hFF,  1'b1, '{STAT_BAD_FREQ, 16'd0, 16'd0, 16'd0}},
    '{CMD_SET_FREQ, 32'hFFFFFFFF,  8'd0,   1'b1, '{STAT_BAD_FREQ, 16'd0, 16'd0, 16'd0}},
    '{CMD_SET_FREQ, 32'd160000,    8'd0,   1'b1, '{STAT_RELOAD_SMALL, 16'd0, 16'd0, 16'd0}},
    '{CMD_SET_DUTY, 32'd0,         8'd100, 1'b1, '{STAT_OK, 16'd0, 16'd0, 16'd1}},
    // smallest reload that is accepted
    '{CMD_SET_FREQ, 32'd158416,    8'd0,   1'b0, NO_RES},
    '{CMD_SET_DUTY, 32'd0,         8'd100, 1'b0, NO_RES},
    '{CMD_SET_DUTY, 32'd0,         8'd1,   1'b0, NO_RES},
    // lowest frequency: prescaler kicks in
    '{CMD_SET_FREQ, 32'd1,         8'd0,   1'b0, NO_RES},
    '{CMD_SET_DUTY, 32'd0,         8'd100, 1'b0, NO_RES},
    '{CMD_SET_DUTY, 32'hAAAAAAAA,  8'd50,  1'b0, NO_RES},
    // reload just past the counter range, then just inside it
    '{CMD_SET_FREQ, 32'd244,       8'd0,   1'b0, NO_RES},
    '{CMD_SET_FREQ, 32'd245,       8'h80,  1'b0, NO_RES},
    '{CMD_SET_DUTY, 32'd0,         8'd99,  1'b0, NO_RES},
    '{CMD_SET_FREQ, 32'd1000,      8'd0,   1'b0, NO_RES},
    '{CMD_SET_DUTY, 32'h55555555,  8'd33,  1'b0, NO_RES},
    // just below timer clock: reload too small, stored values kept
    '{CMD_SET_FREQ, 32'd15999999,  8'd0,   1'b0, NO_RES},
    '{CMD_SET_DUTY, 32'd0,         8'd102, 1'b0, NO_RES}
  };

  // Config phases: bus clock write data, prescaled write data, item count.
  localparam int NUM_PHASES = 9;
  localparam logic [31:0] PH_BUS_HZ [0:NUM_PHASES-1] = '{
    32'd84000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'd1, 32'h80000000,
    32'd0, 32'h80F42400, 32'd0, 32'd180000000
  };
  localparam logic [31:0] PH_BUS_PRE [0:NUM_PHASES-1] = '{
    32'd1, 32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'hFFFFFFFE, 32'd3, 32'd0
  };
  localparam int PH_ITEMS [0:NUM_PHASES-1] = '{
    220, 220, 220, 40, 40, 220, 220, 220, 200
  };

  logic clk = 1'b0;
  logic rst;
  logic rsp_rdy = 1'b0;

  pcc_req_if req_ch ();
  pcc_rsp_if rsp_ch ();
  pcc_cfg_if cfg_ch ();

  assign rsp_ch.ready = rsp_rdy;

  pwm_period_and_compare_calc_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the core's registers and stored timer values.
  logic [30:0]   bus_hz;
  logic          bus_pre;
  logic [15:0]   timer_psc;
  logic [15:0]   timer_arr;

  timer_result_t pending_results [$];
  int            mismatches = 0;
  bit            idling = 1'b0;   // random gaps on both channels

  // Timer clock seen by the counter: bus clock, doubled when prescaled.
  function automatic logic [63:0] timer_clock();
    return bus_pre ? {32'd0, bus_hz, 1'b0} : {33'd0, bus_hz};
  endfunction

  // Timer settings for one request; updates the stored values on success.
  function automatic timer_result_t compute_timer(logic cmd, logic [31:0] freq_hz,
                                                  logic [7:0] duty);
    timer_result_t res;
    logic [63:0]   tclk;
    logic [63:0]   f;
    logic [63:0]   div;
    logic [63:0]   psc;
    res  = '{STAT_OK, 16'd0, 16'd0, 16'd0};
    tclk = timer_clock();
    f    = {32'd0, freq_hz};
    if (cmd == CMD_SET_FREQ) begin
      if (f == 0 || f >= tclk) begin
        res.status = STAT_BAD_FREQ;
      end else begin
        div = (tclk + f / 2) / f;
        psc = 64'd1;
        if (div > 64'(COUNTER_MAX)) begin
          psc = (div + 64'(COUNTER_MAX / 2)) / 64'(COUNTER_MAX) + 64'd1;
          div = div / psc;
        end
        if (div <= 64'(RELOAD_MIN)) begin
          res.status = STAT_RELOAD_SMALL;
        end else if (psc > 64'(COUNTER_MAX) || div > 64'(COUNTER_MAX)) begin
          res.status = STAT_RANGE_OVF;
        end else begin
          timer_psc = 16'(psc - 64'd1);
          timer_arr = 16'(div - 64'd1);
        end
      end
    end else if (duty > 8'(DUTY_MAX)) begin
      res.status = STAT_DUTY_OVER;
    end else if (duty != 8'd0) begin
      res.compare = 16'((32'(timer_arr) * 32'(duty)) / 32'(DUTY_MAX) + 32'd1);
    end
    res.prescaler = timer_psc;
    res.reload    = timer_arr;
    return res;
  endfunction

  // Frequency mostly aimed at the useful range of the current timer clock.
  function automatic logic [31:0] pick_freq();
    logic [63:0] ratio;
    int unsigned nbits;
    case ($urandom % 8)
      0: return $urandom;
      1: return $urandom_range(0, 3000);
      default: begin
        nbits = $urandom_range(3, 33);
        ratio = {$urandom, $urandom} & ((64'd1 << nbits) - 64'd1);
        if (ratio == 0) ratio = 64'd1;
        return 32'(timer_clock() / ratio);
      end
    endcase
  endfunction

  // Issue one request; leaves valid high so a back-to-back request can follow.
  task automatic issue_request(logic cmd, logic [31:0] freq_hz, logic [7:0] duty,
                               logic fixed_res, timer_result_t typed_res);
    timer_result_t predicted;
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= cmd;
    req_ch.freq_hz      <= freq_hz;
    req_ch.duty_percent <= duty;
    do @(posedge clk); while (!req_ch.ready);
    predicted = compute_timer(cmd, freq_hz, duty);
    pending_results.push_back(fixed_res ? typed_res : predicted);
  endtask

  // Register write; valid stays high, the caller drops it after the batch.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (index == REG_BUS_CLOCK_HZ) bus_hz = data[30:0];
    else if (index == REG_BUS_PRESCALED) bus_pre = data[0];
  endtask

  // Random sender gap, only while idling is on.
  task automatic maybe_pause();
    if (idling && ($urandom % 5 == 0)) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Response stall bursts between runs of ready.
  int unsigned stall_left = 0;
  int unsigned run_left   = 0;
  always @(posedge clk) begin
    if (rst || !idling) begin
      rsp_rdy    <= 1'b1;
      stall_left = 0;
      run_left   = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_rdy <= 1'b0;
    end else if (run_left != 0) begin
      run_left--;
      rsp_rdy <= 1'b1;
    end else if ($urandom % 3 == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      rsp_rdy    <= 1'b0;
    end else begin
      run_left = $urandom_range(1, 30);
      rsp_rdy  <= 1'b1;
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    timer_result_t exp_res;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d prescaler %0d reload %0d compare %0d",
               rsp_ch.status, rsp_ch.prescaler, rsp_ch.reload, rsp_ch.compare);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.prescaler !== exp_res.prescaler) begin
          $error("prescaler: expected %0d, got %0d", exp_res.prescaler, rsp_ch.prescaler);
          mismatches++;
        end
        if (rsp_ch.reload !== exp_res.reload) begin
          $error("reload: expected %0d, got %0d", exp_res.reload, rsp_ch.reload);
          mismatches++;
        end
        if (rsp_ch.compare !== exp_res.compare) begin
          $error("compare: expected %0d, got %0d", exp_res.compare, rsp_ch.compare);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then config phases with random requests.
  initial begin
    logic        cmd;
    logic [7:0]  duty;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = CMD_SET_FREQ;
    req_ch.freq_hz      = 32'd0;
    req_ch.duty_percent = 8'd0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_BUS_CLOCK_HZ;
    cfg_ch.data         = '0;
    // reset defaults of the shadow state
    bus_hz    = 31'd16000000;
    bus_pre   = 1'b0;
    timer_psc = 16'd0;
    timer_arr = 16'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset configuration, light idling
    idling = 1'b1;
    foreach (DIRECTED[i]) begin
      issue_request(DIRECTED[i].cmd, DIRECTED[i].freq_hz, DIRECTED[i].duty_percent,
                    DIRECTED[i].fixed_res, DIRECTED[i].res);
      maybe_pause();
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // registers change only with the core idle and nothing outstanding
      drain();
      write_reg(REG_BUS_CLOCK_HZ,
                (ph == 5 || ph == 7) ? CFG_DAT_W'($urandom) : PH_BUS_HZ[ph]);
      write_reg(REG_BUS_PRESCALED,
                (ph == 5) ? CFG_DAT_W'($urandom) : PH_BUS_PRE[ph]);
      // index past the register list: must be ignored
      write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DAT_W'($urandom));
      cfg_ch.valid <= 1'b0;
      // one phase runs flat out, and the last part of the run has no idling
      idling = (ph != 2 && ph != NUM_PHASES - 1);

      // per-phase edges: lowest frequencies and full duty
      issue_request(CMD_SET_FREQ, 32'd1, 8'd0, 1'b0, NO_RES);
      issue_request(CMD_SET_FREQ, 32'd2, 8'd0, 1'b0, NO_RES);
      issue_request(CMD_SET_DUTY, 32'd0, 8'd100, 1'b0, NO_RES);

      for (int n = 0; n < PH_ITEMS[ph]; n++) begin
        maybe_pause();
        cmd  = ($urandom % 2 == 0) ? CMD_SET_FREQ : CMD_SET_DUTY;
        duty = ($urandom % 8 == 0) ? 8'($urandom_range(101, 255))
                                   : 8'($urandom_range(0, 100));
        issue_request(cmd, pick_freq(), duty, 1'b0, NO_RES);
      end
    end

    drain();
    repeat (120) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
